[sv/jmsp_pkg.sv]
// Package for the JPEG marker segment parser.
// Holds result kinds, marker codes, sizes and the structs shared by the modules.
// No dependencies.
package jmsp_pkg;

  localparam int HuffLengths = 16;
  localparam int QuantSide   = 8;
  localparam int QuantCount  = QuantSide * QuantSide;

  localparam logic [2:0] KIND_MARKER    = 3'd0;
  localparam logic [2:0] KIND_LENGTH    = 3'd1;
  localparam logic [2:0] KIND_FIELD     = 3'd2;
  localparam logic [2:0] KIND_DATA      = 3'd3;
  localparam logic [2:0] KIND_MALFORMED = 3'd4;
  localparam logic [2:0] KIND_BAD_HUFF  = 3'd5;

  localparam logic [7:0] MK_SOF = 8'hC0;
  localparam logic [7:0] MK_DHT = 8'hC4;
  localparam logic [7:0] MK_SOI = 8'hD8;
  localparam logic [7:0] MK_EOI = 8'hD9;
  localparam logic [7:0] MK_SOS = 8'hDA;
  localparam logic [7:0] MK_DQT = 8'hDB;
  localparam logic [7:0] MK_APP = 8'hE0;

  localparam logic [7:0] BYTE_PREFIX = 8'hFF;
  localparam logic [7:0] BYTE_STUFF  = 8'h00;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  marker_code;
    logic [4:0]  field_tag;
    logic [7:0]  element_index;
    logic [3:0]  table_number;
    logic [15:0] value;
    logic        segment_done;
    logic        length_mismatch;
  } jmsp_result_t;

  typedef struct packed {
    logic       found;
    logic [3:0] grp;
    logic [7:0] count;
  } jmsp_grp_t;

  typedef struct packed {
    logic halted;
    logic emit;
  } jmsp_status_t;

endpackage

[sv/jmsp_ifs.sv]
// Channel interfaces of the JPEG marker segment parser: byte input, result output.
// No dependencies.
interface jmsp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  modport source(output valid, output byte_value, input ready);
  modport sink(input valid, input byte_value, output ready);
endinterface

interface jmsp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  marker_code;
  logic [4:0]  field_tag;
  logic [7:0]  element_index;
  logic [3:0]  table_number;
  logic [15:0] value;
  logic        segment_done;
  logic        length_mismatch;
  modport source(output valid, output kind, output marker_code, output field_tag,
                 output element_index, output table_number, output value,
                 output segment_done, output length_mismatch, input ready);
  modport sink(input valid, input kind, input marker_code, input field_tag,
               input element_index, input table_number, input value,
               input segment_done, input length_mismatch, output ready);
endinterface

[sv/jmsp_huff_groups.sv]
// Huffman code length count store with nonzero flags and next-group search.
// Depends on jmsp_pkg.
module jmsp_huff_groups (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [3:0]        wr_idx,
  input  logic [7:0]        wr_data,
  input  logic [4:0]        search_from,
  output jmsp_pkg::jmsp_grp_t grp
);
  import jmsp_pkg::*;

  logic [7:0]             counts [HuffLengths];
  logic [HuffLengths-1:0] nonzero;
  logic [HuffLengths-1:0] eff;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      counts[wr_idx]  <= wr_data;
      nonzero[wr_idx] <= (wr_data != 8'd0);
    end
  end

  always_comb begin
    for (int i = 0; i < HuffLengths; i++) begin
      if (wr_en && (wr_idx == 4'(i))) eff[i] = (wr_data != 8'd0);
      else eff[i] = nonzero[i];
    end
    grp.found = 1'b0;
    grp.grp   = 4'd0;
    for (int i = HuffLengths - 1; i >= 0; i--) begin
      if (eff[i] && (5'(i) >= search_from)) begin
        grp.found = 1'b1;
        grp.grp   = 4'(i);
      end
    end
    if (wr_en && (wr_idx == grp.grp)) grp.count = wr_data;
    else grp.count = counts[grp.grp];
  end
endmodule

[sv/jmsp_core.sv]
// Parse state machine: one byte per transaction updates state and forms a result.
// Depends on jmsp_pkg and jmsp_huff_groups.
module jmsp_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             byte_value,
  output jmsp_pkg::jmsp_result_t res,
  output jmsp_pkg::jmsp_status_t status
);
  import jmsp_pkg::*;

  localparam logic [3:0] PM_PREFIX     = 4'd0;
  localparam logic [3:0] PM_CODE       = 4'd1;
  localparam logic [3:0] PM_LEN_HI     = 4'd2;
  localparam logic [3:0] PM_LEN_LO     = 4'd3;
  localparam logic [3:0] PM_BODY       = 4'd4;
  localparam logic [3:0] PM_SCAN       = 4'd5;
  localparam logic [3:0] PM_SCAN_FF    = 4'd6;
  localparam logic [3:0] PM_HALT       = 4'd7;
  localparam logic [3:0] PM_DHT_CLASS  = 4'd8;
  localparam logic [3:0] PM_DHT_COUNTS = 4'd9;
  localparam logic [3:0] PM_DHT_SYMS   = 4'd10;

  logic [3:0]  mode, mode_next;
  logic [7:0]  marker, marker_next;
  logic [15:0] dlen, dlen_next;
  logic [15:0] left, left_next;
  logic [15:0] pos, pos_next;
  logic [7:0]  hold, hold_next;
  logic [7:0]  comps, comps_next;
  logic [3:0]  htc, htc_next;
  logic [4:0]  gi, gi_next;
  logic [7:0]  syms, syms_next;
  logic [1:0]  sof_phase, sof_phase_next;
  logic [7:0]  sof_comp, sof_comp_next;

  logic        emit;
  logic        wr_en;
  logic [4:0]  search_from;
  jmsp_grp_t   grp;
  logic        mm;
  logic [15:0] pos_inc;
  logic [15:0] n2;
  logic [15:0] r;
  logic        last;
  logic        half_high, half_low;
  logic [4:0]  tag;
  logic [7:0]  idx;
  logic        tend;

  jmsp_huff_groups u_groups (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_idx     (gi[3:0]),
    .wr_data    (byte_value),
    .search_from(search_from),
    .grp        (grp)
  );

  assign wr_en       = accept && (mode == PM_DHT_COUNTS);
  assign search_from = (mode == PM_DHT_COUNTS) ? 5'd0 : gi + 5'd1;
  assign pos_inc     = (pos == 16'hFFFF) ? pos : pos + 16'd1;
  assign mm          = (dlen < 16'd2) || (pos_inc != dlen - 16'd2);
  assign n2          = {7'd0, comps, 1'b0};
  assign r           = pos - 16'd1 - n2;

  always_comb begin
    mode_next      = mode;
    marker_next    = marker;
    dlen_next      = dlen;
    left_next      = left;
    pos_next       = pos;
    hold_next      = hold;
    comps_next     = comps;
    htc_next       = htc;
    gi_next        = gi;
    syms_next      = syms;
    sof_phase_next = sof_phase;
    sof_comp_next  = sof_comp;
    emit           = 1'b0;
    res            = '0;
    last           = 1'b0;
    half_high      = 1'b0;
    half_low       = 1'b0;
    tag            = 5'd0;
    idx            = 8'd0;
    tend           = 1'b0;

    case (mode)
      PM_PREFIX: begin
        if (byte_value == BYTE_PREFIX) begin
          mode_next = PM_CODE;
        end else begin
          emit      = 1'b1;
          res.kind  = KIND_MALFORMED;
          res.value = {8'd0, byte_value};
          mode_next = PM_HALT;
        end
      end
      PM_CODE, PM_SCAN_FF: begin
        if ((mode == PM_SCAN_FF) && (byte_value == BYTE_STUFF)) begin
          emit      = 1'b1;
          res.kind  = KIND_DATA;
          res.value = {8'd0, BYTE_PREFIX};
          mode_next = PM_SCAN;
        end else begin
          marker_next = byte_value;
          emit        = 1'b1;
          res.kind    = KIND_MARKER;
          res.value   = {8'd0, byte_value};
          if ((byte_value == MK_SOI) || (byte_value == MK_EOI)) begin
            res.segment_done = 1'b1;
            mode_next        = PM_PREFIX;
          end else begin
            mode_next = PM_LEN_HI;
          end
        end
      end
      PM_LEN_HI: begin
        hold_next = byte_value;
        mode_next = PM_LEN_LO;
      end
      PM_LEN_LO: begin
        dlen_next      = {hold, byte_value};
        hold_next      = 8'd0;
        pos_next       = 16'd0;
        comps_next     = 8'd0;
        htc_next       = 4'd0;
        sof_phase_next = 2'd0;
        sof_comp_next  = 8'd0;
        left_next      = (dlen_next >= 16'd2) ? dlen_next - 16'd2 : 16'd0;
        emit           = 1'b1;
        res.kind       = KIND_LENGTH;
        res.value      = dlen_next;
        if (!((marker == MK_DQT) || (marker == MK_SOS)) && (left_next == 16'd0)) begin
          res.segment_done    = 1'b1;
          res.length_mismatch = (dlen_next < 16'd2);
          mode_next           = PM_PREFIX;
        end else begin
          mode_next = (marker == MK_DHT) ? PM_DHT_CLASS : PM_BODY;
        end
      end
      PM_BODY: begin
        pos_next = pos_inc;
        emit     = 1'b1;
        res.kind = KIND_FIELD;
        if (marker == MK_DQT) begin
          last      = (pos >= 16'(QuantCount));
          res.value = {8'd0, byte_value};
          if (pos != 16'd0) begin
            res.field_tag       = 5'd1;
            res.element_index   = 8'(pos - 16'd1);
            res.segment_done    = last;
            res.length_mismatch = last && mm;
          end
          if (last) mode_next = PM_PREFIX;
        end else if (marker == MK_SOS) begin
          res.value = {8'd0, byte_value};
          if (pos == 16'd0) begin
            comps_next = byte_value;
          end else if (pos <= n2) begin
            res.field_tag     = pos[0] ? 5'd1 : 5'd2;
            res.element_index = 8'((pos - 16'd1) >> 1);
          end else begin
            last                = (r >= 16'd2);
            res.field_tag       = last ? 5'd5 : 5'(16'd3 + r);
            res.segment_done    = last;
            res.length_mismatch = last && mm;
            if (last) mode_next = PM_SCAN;
          end
        end else begin
          left_next = left - 16'd1;
          last      = (left_next == 16'd0);
          idx       = pos[7:0];
          if (marker == MK_APP) begin
            idx = 8'd0;
            if (pos < 16'd5) begin
              idx = pos[7:0];
            end else begin
              case (pos)
                16'd5:   tag = 5'd1;
                16'd6:   tag = 5'd2;
                16'd7:   tag = 5'd3;
                16'd8:   begin tag = 5'd4; half_high = 1'b1; end
                16'd9:   begin tag = 5'd4; half_low = 1'b1; end
                16'd10:  begin tag = 5'd5; half_high = 1'b1; end
                16'd11:  begin tag = 5'd5; half_low = 1'b1; end
                16'd12:  tag = 5'd6;
                16'd13:  tag = 5'd7;
                default: begin tag = 5'd8; idx = pos[7:0] - 8'd14; end
              endcase
            end
          end else if (marker == MK_SOF) begin
            idx = 8'd0;
            case (pos)
              16'd0:   tag = 5'd0;
              16'd1:   begin tag = 5'd1; half_high = 1'b1; end
              16'd2:   begin tag = 5'd1; half_low = 1'b1; end
              16'd3:   begin tag = 5'd2; half_high = 1'b1; end
              16'd4:   begin tag = 5'd2; half_low = 1'b1; end
              16'd5:   tag = 5'd3;
              default: begin
                tag            = 5'd4 + {3'd0, sof_phase};
                idx            = sof_comp;
                sof_phase_next = (sof_phase == 2'd2) ? 2'd0 : sof_phase + 2'd1;
                if (sof_phase == 2'd2) sof_comp_next = sof_comp + 8'd1;
              end
            endcase
          end
          if (last) mode_next = PM_PREFIX;
          res.field_tag     = tag;
          res.element_index = idx;
          if (half_high) begin
            if (!last) begin
              hold_next = byte_value;
              emit      = 1'b0;
            end else begin
              res.value           = {byte_value, 8'd0};
              res.segment_done    = 1'b1;
              res.length_mismatch = 1'b1;
            end
          end else begin
            res.value           = half_low ? {hold, byte_value} : {8'd0, byte_value};
            res.segment_done    = last;
            res.length_mismatch = last && mm;
          end
        end
      end
      PM_DHT_CLASS: begin
        pos_next         = pos_inc;
        emit             = 1'b1;
        res.table_number = htc;
        res.value        = {8'd0, byte_value};
        if (byte_value[7:4] > 4'd3) begin
          res.kind  = KIND_BAD_HUFF;
          mode_next = PM_HALT;
        end else begin
          res.kind  = KIND_FIELD;
          gi_next   = 5'd0;
          mode_next = PM_DHT_COUNTS;
        end
      end
      PM_DHT_COUNTS, PM_DHT_SYMS: begin
        pos_next          = pos_inc;
        emit              = 1'b1;
        res.kind          = KIND_FIELD;
        res.table_number  = htc;
        res.value         = {8'd0, byte_value};
        res.element_index = {3'd0, gi};
        res.field_tag     = (mode == PM_DHT_COUNTS) ? 5'd1 : 5'd2;
        if (mode == PM_DHT_COUNTS) begin
          gi_next = gi + 5'd1;
          if (gi_next >= 5'(HuffLengths)) begin
            if (!grp.found) begin
              tend = 1'b1;
            end else begin
              gi_next   = {1'b0, grp.grp};
              syms_next = grp.count;
              mode_next = PM_DHT_SYMS;
            end
          end
        end else begin
          syms_next = syms - 8'd1;
          if (syms_next == 8'd0) begin
            if (!grp.found) begin
              tend = 1'b1;
            end else begin
              gi_next   = {1'b0, grp.grp};
              syms_next = grp.count;
            end
          end
        end
        if (tend) begin
          htc_next = htc + 4'd1;
          if ((dlen >= 16'd2) && (pos_inc < dlen - 16'd2)) begin
            mode_next = PM_DHT_CLASS;
          end else begin
            res.segment_done    = 1'b1;
            res.length_mismatch = mm;
            mode_next           = PM_PREFIX;
          end
        end
      end
      PM_SCAN: begin
        if (byte_value == BYTE_PREFIX) begin
          mode_next = PM_SCAN_FF;
        end else begin
          emit      = 1'b1;
          res.kind  = KIND_DATA;
          res.value = {8'd0, byte_value};
        end
      end
      PM_HALT: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    res.marker_code = marker_next;
  end

  assign status.halted = (mode == PM_HALT);
  assign status.emit   = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= PM_PREFIX;
      marker    <= 8'd0;
      dlen      <= 16'd0;
      left      <= 16'd0;
      pos       <= 16'd0;
      hold      <= 8'd0;
      comps     <= 8'd0;
      htc       <= 4'd0;
      gi        <= 5'd0;
      syms      <= 8'd0;
      sof_phase <= 2'd0;
      sof_comp  <= 8'd0;
    end else if (accept) begin
      mode      <= mode_next;
      marker    <= marker_next;
      dlen      <= dlen_next;
      left      <= left_next;
      pos       <= pos_next;
      hold      <= hold_next;
      comps     <= comps_next;
      htc       <= htc_next;
      gi        <= gi_next;
      syms      <= syms_next;
      sof_phase <= sof_phase_next;
      sof_comp  <= sof_comp_next;
    end
  end
endmodule

[sv/jmsp_out_reg.sv]
// Result register: holds one result until the downstream transaction completes.
// Depends on jmsp_pkg.
module jmsp_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  jmsp_pkg::jmsp_result_t res,
  input  logic                   out_ready,
  output logic                   out_valid,
  output jmsp_pkg::jmsp_result_t out_res,
  output logic                   can_load
);
  import jmsp_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end
endmodule

[sv/jpeg_marker_segment_parser.sv]
// Top level of the JPEG marker segment parser.
// Depends on jmsp_pkg, jmsp_ifs, jmsp_core and jmsp_out_reg.
//
// Takes one JPEG file byte per transaction and gives at most one tagged result per byte:
// marker codes, segment lengths, decoded header fields of APP0, SOF0, DQT, DHT, SOS and
// COM, and unstuffed scan data. A byte is taken in every cycle while the result register
// is empty or being drained, so the sustained rate is one byte per clock; the parse state
// update ahead of the result register sets that figure. Each result appears in the cycle
// after its byte is taken. A stray byte between segments or a DHT class above 3
// gives an error result and halts the parser until reset.
module jpeg_marker_segment_parser (
  input logic          clk,
  input logic          rst,
  jmsp_byte_if.sink    in_ch,
  jmsp_result_if.source out_ch
);
  import jmsp_pkg::*;

  logic         accept;
  logic         can_load;
  jmsp_result_t res;
  jmsp_result_t out_res;
  jmsp_status_t status;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  jmsp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .byte_value(in_ch.byte_value),
    .res       (res),
    .status    (status)
  );

  jmsp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && status.emit),
    .res      (res),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .out_res  (out_res),
    .can_load (can_load)
  );

  assign out_ch.kind            = out_res.kind;
  assign out_ch.marker_code     = out_res.marker_code;
  assign out_ch.field_tag       = out_res.field_tag;
  assign out_ch.element_index   = out_res.element_index;
  assign out_ch.table_number    = out_res.table_number;
  assign out_ch.value           = out_res.value;
  assign out_ch.segment_done    = out_res.segment_done;
  assign out_ch.length_mismatch = out_res.length_mismatch;

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    status.halted |=> status.halted)
    else $error("parser left halt without reset");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    status.halted |-> !status.emit)
    else $error("halted parser produced a result");

  a_mismatch_done: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.length_mismatch) |-> out_ch.segment_done)
    else $error("length mismatch without segment end");
endmodule

[sim/jmsp_result_checker.sv]
// Result checker for the JPEG marker segment parser: watches both channels, keeps its own
// copy of the parse state, predicts each result and compares it field by field.
// Depends on jmsp_pkg and jmsp_ifs.
module jmsp_result_checker (
  input  logic   clk,
  input  logic   rst,
  jmsp_byte_if   in_ch,
  jmsp_result_if out_ch,
  output int     errors,
  output int     pending
);
  import jmsp_pkg::*;

  typedef enum logic [3:0] {
    M_PREFIX, M_CODE, M_LEN_HI, M_LEN_LO, M_BODY, M_SCAN, M_SCAN_FF, M_HALT,
    M_DHT_CLASS, M_DHT_COUNTS, M_DHT_SYMS
  } parse_mode_t;

  parse_mode_t  mode;
  logic [7:0]   cur_mk;
  logic [15:0]  seg_len;
  logic [15:0]  left;
  logic [15:0]  pos;
  logic [7:0]   hold;
  logic [7:0]   ncomp;
  logic [3:0]   tbl;
  logic [7:0]   counts [HuffLengths];
  logic [4:0]   grp;
  logic [7:0]   syms;
  jmsp_result_t expected_q [$];
  int           seen;

  function automatic jmsp_result_t pack_result(int kind, int tag, int idx, int tn,
                                               int val, logic done, logic mis);
    jmsp_result_t r;
    r.kind            = 3'(kind);
    r.marker_code     = cur_mk;
    r.field_tag       = 5'(tag);
    r.element_index   = 8'(idx);
    r.table_number    = 4'(tn);
    r.value           = 16'(val);
    r.segment_done    = done;
    r.length_mismatch = mis;
    return r;
  endfunction

  function automatic logic seg_mismatch();
    if (seg_len < 16'd2) return 1'b1;
    return {1'b0, pos} != ({1'b0, seg_len} - 17'd2);
  endfunction

  function automatic int next_group(int from);
    for (int g = from; g < HuffLengths; g++) if (counts[g] != 8'd0) return g;
    return -1;
  endfunction

  task automatic clear_state();
    mode    = M_PREFIX;
    cur_mk  = '0;
    seg_len = '0;
    left    = '0;
    pos     = '0;
    hold    = '0;
    ncomp   = '0;
    tbl     = '0;
    grp     = '0;
    syms    = '0;
    for (int i = 0; i < HuffLengths; i++) counts[i] = '0;
  endtask

  task automatic bump();
    if (pos != 16'hFFFF) pos++;
  endtask

  task automatic start_marker(input logic [7:0] b, output jmsp_result_t r);
    cur_mk = b;
    if (b == MK_SOI || b == MK_EOI) begin
      r = pack_result(KIND_MARKER, 0, 0, 0, b, 1'b1, 1'b0);
      mode = M_PREFIX;
    end else begin
      r = pack_result(KIND_MARKER, 0, 0, 0, b, 1'b0, 1'b0);
      mode = M_LEN_HI;
    end
  endtask

  task automatic close_table(input int tag, input int idx, input int val,
                             output jmsp_result_t r);
    logic [3:0] t;
    t = tbl;
    tbl++;
    if (seg_len >= 16'd2 && {1'b0, pos} < ({1'b0, seg_len} - 17'd2)) begin
      r = pack_result(KIND_FIELD, tag, idx, t, val, 1'b0, 1'b0);
      mode = M_DHT_CLASS;
    end else begin
      r = pack_result(KIND_FIELD, tag, idx, t, val, 1'b1, seg_mismatch());
      mode = M_PREFIX;
    end
  endtask

  task automatic dht_byte(input logic [7:0] b, output jmsp_result_t r);
    logic [4:0] gi;
    int         g;
    gi = grp;
    bump();
    case (mode)
      M_DHT_CLASS: begin
        if (b[7:4] > 4'd3) begin
          r = pack_result(KIND_BAD_HUFF, 0, 0, tbl, b, 1'b0, 1'b0);
          mode = M_HALT;
        end else begin
          r = pack_result(KIND_FIELD, 0, 0, tbl, b, 1'b0, 1'b0);
          grp = '0;
          mode = M_DHT_COUNTS;
        end
      end
      M_DHT_COUNTS: begin
        counts[gi[3:0]] = b;
        grp = gi + 5'd1;
        if (grp < 5'd16) begin
          r = pack_result(KIND_FIELD, 1, gi, tbl, b, 1'b0, 1'b0);
        end else begin
          g = next_group(0);
          if (g < 0) begin
            close_table(1, gi, b, r);
          end else begin
            grp = 5'(g);
            syms = counts[g];
            mode = M_DHT_SYMS;
            r = pack_result(KIND_FIELD, 1, gi, tbl, b, 1'b0, 1'b0);
          end
        end
      end
      default: begin
        syms--;
        if (syms != 8'd0) begin
          r = pack_result(KIND_FIELD, 2, gi, tbl, b, 1'b0, 1'b0);
        end else begin
          g = next_group(int'(gi) + 1);
          if (g < 0) begin
            close_table(2, gi, b, r);
          end else begin
            grp = 5'(g);
            syms = counts[g];
            r = pack_result(KIND_FIELD, 2, gi, tbl, b, 1'b0, 1'b0);
          end
        end
      end
    endcase
  endtask

  task automatic body_byte(input logic [7:0] b, output bit have, output jmsp_result_t r);
    int   p;
    int   n;
    int   rr;
    int   tag;
    int   idx;
    int   half;
    logic last;
    p = pos;
    bump();
    have = 1;
    tag = 0;
    idx = 0;
    half = 0;
    if (cur_mk == MK_DQT) begin
      last = p >= QuantCount;
      if (p == 0) r = pack_result(KIND_FIELD, 0, 0, 0, b, 1'b0, 1'b0);
      else r = pack_result(KIND_FIELD, 1, p - 1, 0, b, last, last && seg_mismatch());
      if (last) mode = M_PREFIX;
    end else if (cur_mk == MK_SOS) begin
      n = ncomp;
      if (p == 0) begin
        ncomp = b;
        r = pack_result(KIND_FIELD, 0, 0, 0, b, 1'b0, 1'b0);
      end else if (p <= 2 * n) begin
        r = pack_result(KIND_FIELD, (p % 2) ? 1 : 2, (p - 1) / 2, 0, b, 1'b0, 1'b0);
      end else begin
        rr = p - 1 - 2 * n;
        last = rr >= 2;
        r = pack_result(KIND_FIELD, 3 + ((rr > 2) ? 2 : rr), 0, 0, b, last,
                        last && seg_mismatch());
        if (last) mode = M_SCAN;
      end
    end else begin
      left--;
      last = left == 16'd0;
      if (cur_mk == MK_APP) begin
        if (p < 5) begin
          idx = p;
        end else begin
          case (p)
            5: tag = 1;
            6: tag = 2;
            7: tag = 3;
            8: begin tag = 4; half = 1; end
            9: begin tag = 4; half = 2; end
            10: begin tag = 5; half = 1; end
            11: begin tag = 5; half = 2; end
            12: tag = 6;
            13: tag = 7;
            default: begin tag = 8; idx = p - 14; end
          endcase
        end
      end else if (cur_mk == MK_SOF) begin
        case (p)
          0: tag = 0;
          1: begin tag = 1; half = 1; end
          2: begin tag = 1; half = 2; end
          3: begin tag = 2; half = 1; end
          4: begin tag = 2; half = 2; end
          5: begin tag = 3; ncomp = b; end
          default: begin tag = 4 + (p - 6) % 3; idx = (p - 6) / 3; end
        endcase
      end else begin
        idx = p;
      end
      if (last) mode = M_PREFIX;
      if (half == 1) begin
        if (!last) begin
          hold = b;
          have = 0;
        end else begin
          r = pack_result(KIND_FIELD, tag, idx, 0, {b, 8'h00}, 1'b1, 1'b1);
        end
      end else if (half == 2) begin
        r = pack_result(KIND_FIELD, tag, idx, 0, {hold, b}, last, last && seg_mismatch());
      end else begin
        r = pack_result(KIND_FIELD, tag, idx, 0, b, last, last && seg_mismatch());
      end
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, output bit have, output jmsp_result_t r);
    have = 0;
    r = '0;
    case (mode)
      M_PREFIX: begin
        if (b == BYTE_PREFIX) begin
          mode = M_CODE;
        end else begin
          r = pack_result(KIND_MALFORMED, 0, 0, 0, b, 1'b0, 1'b0);
          have = 1;
          mode = M_HALT;
        end
      end
      M_CODE: begin
        start_marker(b, r);
        have = 1;
      end
      M_LEN_HI: begin
        hold = b;
        mode = M_LEN_LO;
      end
      M_LEN_LO: begin
        seg_len = {hold, b};
        hold = '0;
        pos = '0;
        ncomp = '0;
        tbl = '0;
        left = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
        have = 1;
        if (!(cur_mk == MK_DQT || cur_mk == MK_SOS) && left == 16'd0) begin
          r = pack_result(KIND_LENGTH, 0, 0, 0, seg_len, 1'b1, seg_mismatch());
          mode = M_PREFIX;
        end else begin
          r = pack_result(KIND_LENGTH, 0, 0, 0, seg_len, 1'b0, 1'b0);
          mode = (cur_mk == MK_DHT) ? M_DHT_CLASS : M_BODY;
        end
      end
      M_BODY: body_byte(b, have, r);
      M_DHT_CLASS, M_DHT_COUNTS, M_DHT_SYMS: begin
        dht_byte(b, r);
        have = 1;
      end
      M_SCAN: begin
        if (b == BYTE_PREFIX) begin
          mode = M_SCAN_FF;
        end else begin
          r = pack_result(KIND_DATA, 0, 0, 0, b, 1'b0, 1'b0);
          have = 1;
        end
      end
      M_SCAN_FF: begin
        have = 1;
        if (b == BYTE_STUFF) begin
          mode = M_SCAN;
          r = pack_result(KIND_DATA, 0, 0, 0, BYTE_PREFIX, 1'b0, 1'b0);
        end else begin
          start_marker(b, r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, int got, int want);
    $display("result %0d: %s got 0x%0h expected 0x%0h", seen, what, got, want);
    errors++;
  endtask

  task automatic compare_result();
    jmsp_result_t e;
    if (expected_q.size() == 0) begin
      report("unexpected result, value", out_ch.value, 0);
    end else begin
      e = expected_q.pop_front();
      if (out_ch.kind !== e.kind) report("kind", out_ch.kind, e.kind);
      if (out_ch.marker_code !== e.marker_code)
        report("marker_code", out_ch.marker_code, e.marker_code);
      if (out_ch.field_tag !== e.field_tag) report("field_tag", out_ch.field_tag, e.field_tag);
      if (out_ch.element_index !== e.element_index)
        report("element_index", out_ch.element_index, e.element_index);
      if (out_ch.table_number !== e.table_number)
        report("table_number", out_ch.table_number, e.table_number);
      if (out_ch.value !== e.value) report("value", out_ch.value, e.value);
      if (out_ch.segment_done !== e.segment_done)
        report("segment_done", out_ch.segment_done, e.segment_done);
      if (out_ch.length_mismatch !== e.length_mismatch)
        report("length_mismatch", out_ch.length_mismatch, e.length_mismatch);
    end
    seen++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
    seen = 0;
    clear_state();
  end

  always @(posedge clk) begin : watch
    bit           have;
    jmsp_result_t r;
    if (rst) begin
      clear_state();
      expected_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) compare_result();
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(in_ch.byte_value, have, r);
        if (have) expected_q.push_back(r);
      end
    end
    pending = expected_q.size();
  end

endmodule

[sim/tb_jpeg_marker_segment_parser.sv]
// Testbench top for the JPEG marker segment parser: drives byte streams of well-formed
// and damaged segments with random idling and gives the verdict.
// Depends on jmsp_pkg, jmsp_ifs, jpeg_marker_segment_parser and jmsp_result_checker.
module tb_jpeg_marker_segment_parser;
  import jmsp_pkg::*;

  localparam int IdleLimit = 4000;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   sent;
  int   idle_cycles;
  bit   no_idle;
  int   stall_left;

  jmsp_byte_if   in_ch ();
  jmsp_result_if out_ch ();

  jpeg_marker_segment_parser dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  jmsp_result_checker result_check (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_jpeg_marker_segment_parser: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic put_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.byte_value <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic put_marker(input logic [7:0] code);
    put_byte(BYTE_PREFIX);
    put_byte(code);
  endtask

  task automatic put_len(input logic [15:0] len);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
  endtask

  task automatic seg_counted(input logic [7:0] code, input int n);
    put_marker(code);
    put_len(16'(n + 2));
    for (int i = 0; i < n; i++) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic seg_short(input logic [7:0] code, input logic [15:0] len);
    put_marker(code);
    put_len(len);
  endtask

  task automatic seg_dqt(input logic [15:0] len);
    put_marker(MK_DQT);
    put_len(len);
    for (int i = 0; i <= QuantCount; i++) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic seg_dht(input int ntab, input bit shorten, input bit bad, input int cmax);
    logic [7:0] body [$];
    int         first_size;
    int         nsym;
    logic [7:0] c;
    for (int t = 0; t < ntab; t++) begin
      if (bad && t == ntab - 1)
        body.push_back({4'($urandom_range(4, 15)), 4'($urandom_range(0, 15))});
      else
        body.push_back({4'($urandom_range(0, 3)), 4'($urandom_range(0, 15))});
      nsym = 0;
      for (int g = 0; g < HuffLengths; g++) begin
        c = (cmax == 0 || $urandom_range(0, 3) != 0) ? 8'd0 : 8'($urandom_range(1, cmax));
        body.push_back(c);
        nsym += c;
      end
      for (int s = 0; s < nsym; s++) body.push_back(8'($urandom_range(0, 255)));
      if (t == 0) first_size = body.size();
    end
    put_marker(MK_DHT);
    if (shorten) begin
      put_len(16'(2 + $urandom_range(1, first_size)));
      for (int i = 0; i < first_size; i++) put_byte(body[i]);
    end else begin
      put_len(16'(2 + body.size()));
      foreach (body[i]) put_byte(body[i]);
    end
  endtask

  task automatic seg_sos(input int nc, input bit wrong_len, input int scan_n);
    logic [7:0] b;
    put_marker(MK_SOS);
    put_len(16'(wrong_len ? $urandom_range(0, 20) : 6 + 2 * nc));
    put_byte(8'(nc));
    for (int i = 0; i < 2 * nc + 3; i++) put_byte(8'($urandom_range(0, 255)));
    for (int i = 0; i < scan_n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == BYTE_PREFIX || $urandom_range(0, 7) == 0) begin
        put_byte(BYTE_PREFIX);
        put_byte(BYTE_STUFF);
      end else begin
        put_byte(b);
      end
    end
  endtask

  function automatic logic [7:0] other_code();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (c == MK_SOI || c == MK_EOI || c == MK_SOF || c == MK_DHT || c == MK_SOS ||
           c == MK_DQT || c == MK_APP);
    return c;
  endfunction

  task automatic random_segment();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) put_marker($urandom_range(0, 1) ? MK_SOI : MK_EOI);
    else if (r < 22) seg_counted(MK_APP, $urandom_range(0, 3) ? $urandom_range(13, 17)
                                                              : $urandom_range(0, 20));
    else if (r < 36) seg_counted(MK_SOF, $urandom_range(0, 3) ? 6 + 3 * $urandom_range(0, 3)
                                                              : $urandom_range(0, 15));
    else if (r < 44) seg_dqt($urandom_range(0, 3) ? 16'd67 : 16'($urandom_range(0, 100)));
    else if (r < 64) seg_dht($urandom_range(1, 3), $urandom_range(0, 5) == 0, 1'b0,
                             $urandom_range(0, 9) == 0 ? 0 : 3);
    else if (r < 82) seg_sos($urandom_range(0, 4), $urandom_range(0, 5) == 0,
                             $urandom_range(0, 30));
    else if (r < 94) seg_counted($urandom_range(0, 1) ? 8'hFE : other_code(),
                                 $urandom_range(0, 10));
    else begin
      case ($urandom_range(0, 4))
        0: seg_short(MK_APP, 16'($urandom_range(0, 2)));
        1: seg_short(MK_SOF, 16'($urandom_range(0, 2)));
        2: seg_short(MK_DHT, 16'($urandom_range(0, 2)));
        default: seg_short(other_code(), 16'($urandom_range(0, 2)));
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.byte_value = '0;
    out_ch.ready = 1'b0;
    sent = 0;
    idle_cycles = 0;
    no_idle = 1'b0;
    stall_left = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    put_marker(MK_SOI);
    seg_counted(8'h00, 1);
    seg_counted(MK_APP, 16);
    seg_counted(MK_APP, 9);
    seg_counted(MK_SOF, 15);
    seg_counted(MK_SOF, 2);
    seg_dqt(16'd67);
    seg_dqt(16'd1);
    seg_dht(2, 1'b0, 1'b0, 3);
    seg_dht(1, 1'b0, 1'b0, 0);
    seg_dht(1, 1'b0, 1'b0, 8);
    seg_dht(2, 1'b1, 1'b0, 2);
    seg_short(MK_DHT, 16'd1);
    seg_short(8'hFE, 16'd0);
    seg_short(MK_APP, 16'd18);
    for (int i = 0; i < 16; i++) put_byte(8'h00);
    seg_counted(BYTE_PREFIX, 3);
    seg_sos(3, 1'b0, 20);
    seg_counted(8'hFE, 258);
    seg_sos(0, 1'b1, 5);
    put_marker(MK_EOI);

    while (sent < 600) begin
      if ($urandom_range(0, 15) == 0) no_idle = ~no_idle;
      random_segment();
    end
    no_idle = 1'b0;

    put_marker(MK_EOI);
    if ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 254)));
    else seg_dht(1, 1'b0, 1'b1, 3);
    repeat (3) put_byte(8'($urandom_range(0, 255)));
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb_jpeg_marker_segment_parser: clean");
    end else begin
      $display("tb_jpeg_marker_segment_parser: errors");
    end
    $finish;
  end

endmodule
